### hdl/tsf_pkg.sv
// shared types and constants for the tcp syn acl packet filter
// used by tsf_frame_check, tsf_rule_table and tcp_syn_acl_packet_filter_core
package tsf_pkg;

	localparam int RULE_COUNT = 16;
	localparam int KEY_W      = 56;
	localparam int COUNT_W    = 64;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'h06;
	localparam logic [16:0] ETH_HDR_BYTES  = 17'd14;
	localparam logic [16:0] IPV4_MIN_END   = 17'd34;
	localparam logic [16:0] TCP_HDR_BYTES  = 17'd20;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		CMD_CLASSIFY = 2'd0,
		CMD_WRITE    = 2'd1,
		CMD_READ     = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		VERDICT_ABORTED = 2'd0,
		VERDICT_DROP    = 2'd1,
		VERDICT_PASS    = 2'd2
	} verdict_t;

	// header checks: verdict before lookup, and whether a lookup decides it
	typedef struct packed {
		verdict_t verdict;
		logic     lookup;
	} chk_t;

	typedef struct packed {
		logic       commit;
		logic       lookup;
		logic       write;
		key_t       key;
		logic [3:0] index;
		logic       enable;
	} tbl_req_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] hit_index;
		count_t     hit_count;
		count_t     rd_count;
		logic       rd_valid;
	} tbl_rsp_t;

	function automatic key_t make_key(logic [31:0] src, logic [15:0] port,
		logic [7:0] proto);
		return {src, port, proto};
	endfunction

endpackage

### hdl/tsf_frame_check.sv
// header sanity checks for a classify request: length, ethertype, protocol, syn
// depends on tsf_pkg
module tsf_frame_check (
	input  logic [15:0]   frame_length,
	input  logic [15:0]   ethertype,
	input  logic [3:0]    header_words,
	input  logic [7:0]    ip_protocol,
	input  logic          syn_flag,
	input  logic          ack_flag,
	output tsf_pkg::chk_t chk
);

	logic [16:0] len;
	logic [16:0] tcp_end;

	assign len     = {1'b0, frame_length};
	assign tcp_end = tsf_pkg::ETH_HDR_BYTES + {11'd0, header_words, 2'b00}
		+ tsf_pkg::TCP_HDR_BYTES;

	always_comb begin
		chk.lookup = 1'b0;
		if (len < tsf_pkg::ETH_HDR_BYTES) begin
			chk.verdict = tsf_pkg::VERDICT_ABORTED;
		end else if (ethertype != tsf_pkg::ETHERTYPE_IPV4) begin
			chk.verdict = tsf_pkg::VERDICT_DROP;
		end else if (len < tsf_pkg::IPV4_MIN_END) begin
			chk.verdict = tsf_pkg::VERDICT_ABORTED;
		end else if (ip_protocol != tsf_pkg::PROTO_TCP) begin
			chk.verdict = tsf_pkg::VERDICT_DROP;
		end else if (len < tcp_end) begin
			chk.verdict = tsf_pkg::VERDICT_ABORTED;
		end else if (!(syn_flag && !ack_flag)) begin
			chk.verdict = tsf_pkg::VERDICT_PASS;
		end else begin
			// bare syn: table lookup decides
			chk.verdict = tsf_pkg::VERDICT_DROP;
			chk.lookup  = 1'b1;
		end
	end

endmodule

### hdl/tsf_rule_table.sv
// rule table: keys, valid bits and hit counters with parallel key match
// depends on tsf_pkg
module tsf_rule_table (
	input  logic              clk,
	input  logic              arst_n,
	input  tsf_pkg::tbl_req_t req,
	output tsf_pkg::tbl_rsp_t rsp
);

	tsf_pkg::key_t   keys_q   [tsf_pkg::RULE_COUNT];
	tsf_pkg::count_t counts_q [tsf_pkg::RULE_COUNT];
	logic [tsf_pkg::RULE_COUNT-1:0] valid_q;

	logic            hit;
	int              hit_sel;
	tsf_pkg::count_t hit_cur;
	tsf_pkg::count_t hit_next;
	tsf_pkg::count_t rd_count;
	logic            rd_valid;

	// lowest matching valid slot wins
	always_comb begin
		hit     = 1'b0;
		hit_sel = 0;
		hit_cur = '0;
		for (int i = tsf_pkg::RULE_COUNT - 1; i >= 0; i--) begin
			if (valid_q[i] && keys_q[i] == req.key) begin
				hit     = 1'b1;
				hit_sel = i;
				hit_cur = counts_q[i];
			end
		end
	end

	assign hit_next = hit_cur + tsf_pkg::count_t'(1);

	// out-of-range slot reads as zero
	always_comb begin
		rd_count = '0;
		rd_valid = 1'b0;
		for (int i = 0; i < tsf_pkg::RULE_COUNT; i++) begin
			if (i == int'(req.index)) begin
				rd_count = counts_q[i];
				rd_valid = valid_q[i];
			end
		end
	end

	assign rsp.hit       = hit;
	assign rsp.hit_index = hit_sel[3:0];
	assign rsp.hit_count = hit_next;
	assign rsp.rd_count  = rd_count;
	assign rsp.rd_valid  = rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < tsf_pkg::RULE_COUNT; i++) begin
				keys_q[i]   <= '0;
				counts_q[i] <= '0;
			end
		end else if (req.commit) begin
			for (int i = 0; i < tsf_pkg::RULE_COUNT; i++) begin
				if (req.write && i == int'(req.index)) begin
					keys_q[i]   <= req.key;
					valid_q[i]  <= req.enable;
					counts_q[i] <= '0;
				end else if (req.lookup && hit && i == hit_sel) begin
					counts_q[i] <= hit_next;
				end
			end
		end
	end

endmodule

### hdl/tcp_syn_acl_packet_filter_core.sv
// tcp syn acl packet filter top level: input register, checks and lookup, result register
// the result register loads from the input register when it is empty or out_stall is low
// throughput: one request per cycle while out_stall does not hold a full result register; lookup is combinational
// reset: all rule slots invalid, keys and counters zero, both stages empty
// depends on tsf_pkg, tsf_frame_check, tsf_rule_table
module tcp_syn_acl_packet_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] frame_length,
	input  logic [15:0] ethertype,
	input  logic [3:0]  header_words,
	input  logic [7:0]  ip_protocol,
	input  logic [31:0] src_address,
	input  logic [15:0] dest_port,
	input  logic        syn_flag,
	input  logic        ack_flag,
	input  logic [3:0]  rule_index,
	input  logic        rule_enable,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  verdict,
	output logic        matched,
	output logic [3:0]  match_index,
	output logic [63:0] hit_count,
	output logic        entry_valid
);

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] frame_length_s1;
	logic [15:0] ethertype_s1;
	logic [3:0]  header_words_s1;
	logic [7:0]  ip_protocol_s1;
	logic [31:0] src_address_s1;
	logic [15:0] dest_port_s1;
	logic        syn_flag_s1;
	logic        ack_flag_s1;
	logic [3:0]  rule_index_s1;
	logic        rule_enable_s1;

	logic        valid_s2;
	logic [1:0]  verdict_s2;
	logic        matched_s2;
	logic [3:0]  match_index_s2;
	logic [63:0] hit_count_s2;
	logic        entry_valid_s2;

	logic              advance;
	logic              accept;
	tsf_pkg::chk_t     chk;
	tsf_pkg::tbl_req_t req;
	tsf_pkg::tbl_rsp_t rsp;

	tsf_pkg::verdict_t verdict_d;
	logic              matched_d;
	logic [3:0]        match_index_d;
	tsf_pkg::count_t   hit_count_d;
	logic              entry_valid_d;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1          <= cmd;
			frame_length_s1 <= frame_length;
			ethertype_s1    <= ethertype;
			header_words_s1 <= header_words;
			ip_protocol_s1  <= ip_protocol;
			src_address_s1  <= src_address;
			dest_port_s1    <= dest_port;
			syn_flag_s1     <= syn_flag;
			ack_flag_s1     <= ack_flag;
			rule_index_s1   <= rule_index;
			rule_enable_s1  <= rule_enable;
		end
	end

	tsf_frame_check u_check (
		.frame_length (frame_length_s1),
		.ethertype    (ethertype_s1),
		.header_words (header_words_s1),
		.ip_protocol  (ip_protocol_s1),
		.syn_flag     (syn_flag_s1),
		.ack_flag     (ack_flag_s1),
		.chk          (chk)
	);

	// table state changes on the edge that moves the request into the result register
	assign req.commit = advance;
	assign req.lookup = (cmd_s1 == tsf_pkg::CMD_CLASSIFY) && chk.lookup;
	assign req.write  = (cmd_s1 == tsf_pkg::CMD_WRITE);
	assign req.key    = tsf_pkg::make_key(src_address_s1, dest_port_s1, ip_protocol_s1);
	assign req.index  = rule_index_s1;
	assign req.enable = rule_enable_s1;

	tsf_rule_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		verdict_d     = tsf_pkg::VERDICT_DROP;
		matched_d     = 1'b0;
		match_index_d = '0;
		hit_count_d   = '0;
		entry_valid_d = 1'b0;
		case (tsf_pkg::cmd_t'(cmd_s1))
			tsf_pkg::CMD_CLASSIFY: begin
				verdict_d = chk.verdict;
				if (chk.lookup && rsp.hit) begin
					verdict_d     = tsf_pkg::VERDICT_PASS;
					matched_d     = 1'b1;
					match_index_d = rsp.hit_index;
					hit_count_d   = rsp.hit_count;
				end
			end
			tsf_pkg::CMD_READ: begin
				hit_count_d   = rsp.rd_count;
				entry_valid_d = rsp.rd_valid;
			end
			default: begin
				verdict_d = tsf_pkg::VERDICT_DROP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_s2     <= verdict_d;
			matched_s2     <= matched_d;
			match_index_s2 <= match_index_d;
			hit_count_s2   <= hit_count_d;
			entry_valid_s2 <= entry_valid_d;
		end
	end

	assign out_valid   = valid_s2;
	assign verdict     = verdict_s2;
	assign matched     = matched_s2;
	assign match_index = match_index_s2;
	assign hit_count   = hit_count_s2;
	assign entry_valid = entry_valid_s2;

endmodule

### verif/tsf_verdict_checker.sv
// verdict checker for the tcp syn acl packet filter: watches both channels, keeps its own rule
// table, predicts one result per accepted request and compares it with the block's output
// depends on tsf_pkg
`timescale 1ns / 1ps

module tsf_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] frame_length,
	input  logic [15:0] ethertype,
	input  logic [3:0]  header_words,
	input  logic [7:0]  ip_protocol,
	input  logic [31:0] src_address,
	input  logic [15:0] dest_port,
	input  logic        syn_flag,
	input  logic        ack_flag,
	input  logic [3:0]  rule_index,
	input  logic        rule_enable,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  verdict,
	input  logic        matched,
	input  logic [3:0]  match_index,
	input  logic [63:0] hit_count,
	input  logic        entry_valid,
	output int          mismatches,
	output int          waiting,
	output int          results_checked,
	output int          rule_hits
);

	typedef struct {
		tsf_pkg::verdict_t verdict;
		logic              matched;
		logic [3:0]        slot;
		tsf_pkg::count_t   count;
		logic              valid;
	} filter_result_t;

	tsf_pkg::key_t   slot_key  [tsf_pkg::RULE_COUNT];
	logic            slot_on   [tsf_pkg::RULE_COUNT];
	tsf_pkg::count_t slot_hits [tsf_pkg::RULE_COUNT];

	filter_result_t expected_q[$];

	always @(posedge clk or negedge arst_n) begin
		filter_result_t want;
		tsf_pkg::key_t  pkt_key;
		logic [16:0]    len;
		logic [16:0]    tcp_end;
		logic           found;
		int             i;
		if (!arst_n) begin
			for (i = 0; i < tsf_pkg::RULE_COUNT; i++) begin
				slot_key[i]  = '0;
				slot_on[i]   = 1'b0;
				slot_hits[i] = '0;
			end
			expected_q.delete();
			mismatches      = 0;
			waiting         = 0;
			results_checked = 0;
			rule_hits       = 0;
		end else begin
			// compare before predicting so a same-cycle request never meets its own result
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (expected_q.size() == 0) begin
					$error("result with no request pending: verdict %0d", verdict);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					results_checked++;
					if (verdict !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict, verdict);
						mismatches++;
					end
					if (matched !== want.matched) begin
						$error("matched: expected %0d, got %0d", want.matched, matched);
						mismatches++;
					end
					if (match_index !== want.slot) begin
						$error("match_index: expected %0d, got %0d", want.slot, match_index);
						mismatches++;
					end
					if (hit_count !== want.count) begin
						$error("hit_count: expected %0d, got %0d", want.count, hit_count);
						mismatches++;
					end
					if (entry_valid !== want.valid) begin
						$error("entry_valid: expected %0d, got %0d", want.valid, entry_valid);
						mismatches++;
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				want = '{tsf_pkg::VERDICT_DROP, 1'b0, 4'd0, '0, 1'b0};
				case (cmd)
					tsf_pkg::CMD_CLASSIFY: begin
						len     = {1'b0, frame_length};
						tcp_end = tsf_pkg::ETH_HDR_BYTES + tsf_pkg::TCP_HDR_BYTES
							+ {11'd0, header_words, 2'b00};
						if (len < tsf_pkg::ETH_HDR_BYTES)
							want.verdict = tsf_pkg::VERDICT_ABORTED;
						else if (ethertype != tsf_pkg::ETHERTYPE_IPV4)
							want.verdict = tsf_pkg::VERDICT_DROP;
						else if (len < tsf_pkg::IPV4_MIN_END)
							want.verdict = tsf_pkg::VERDICT_ABORTED;
						else if (ip_protocol != tsf_pkg::PROTO_TCP)
							want.verdict = tsf_pkg::VERDICT_DROP;
						else if (len < tcp_end)
							want.verdict = tsf_pkg::VERDICT_ABORTED;
						else if (!(syn_flag && !ack_flag))
							want.verdict = tsf_pkg::VERDICT_PASS;
						else begin
							// bare syn: lowest valid slot with the same key wins
							pkt_key = {src_address, dest_port, ip_protocol};
							found   = 1'b0;
							for (i = 0; i < tsf_pkg::RULE_COUNT && !found; i++) begin
								if (slot_on[i] && slot_key[i] == pkt_key) begin
									found        = 1'b1;
									slot_hits[i] = slot_hits[i] + 1'b1;
									want = '{tsf_pkg::VERDICT_PASS, 1'b1, 4'(i),
										slot_hits[i], 1'b0};
									rule_hits++;
								end
							end
						end
					end
					tsf_pkg::CMD_WRITE: begin
						if (rule_index < tsf_pkg::RULE_COUNT) begin
							slot_key[rule_index]  = {src_address, dest_port, ip_protocol};
							slot_on[rule_index]   = rule_enable;
							slot_hits[rule_index] = '0;
						end
					end
					tsf_pkg::CMD_READ: begin
						if (rule_index < tsf_pkg::RULE_COUNT) begin
							want.count = slot_hits[rule_index];
							want.valid = slot_on[rule_index];
						end
					end
					default: ;
				endcase
				expected_q.push_back(want);
			end
			waiting = expected_q.size();
		end
	end

endmodule

### verif/tb_tcp_syn_acl_packet_filter_core.sv
// testbench top for tcp_syn_acl_packet_filter_core: directed header and rule table cases, then
// random requests with idle gaps and output stalls; checking is done by tsf_verdict_checker
// depends on tsf_pkg, tsf_verdict_checker and the filter rtl
`timescale 1ns / 1ps

module tb_tcp_syn_acl_packet_filter_core;

	localparam logic [1:0]  CMD_UNUSED     = 2'd3;
	localparam logic [15:0] ETHERTYPE_IPV4 = tsf_pkg::ETHERTYPE_IPV4;
	localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]  PROTO_TCP      = tsf_pkg::PROTO_TCP;
	localparam logic [7:0]  PROTO_UDP      = 8'h11;
	localparam logic [31:0] SRC_A          = 32'hC0A8_0001;
	localparam logic [15:0] PORT_A         = 16'd80;
	localparam logic [31:0] SRC_B          = 32'h0A00_0002;
	localparam logic [15:0] PORT_B         = 16'd443;
	localparam int          RANDOM_ITEMS   = 1700;
	localparam int          POOL_SIZE      = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [15:0] frame_length;
	logic [15:0] ethertype;
	logic [3:0]  header_words;
	logic [7:0]  ip_protocol;
	logic [31:0] src_address;
	logic [15:0] dest_port;
	logic        syn_flag;
	logic        ack_flag;
	logic [3:0]  rule_index;
	logic        rule_enable;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  verdict;
	logic        matched;
	logic [3:0]  match_index;
	logic [63:0] hit_count;
	logic        entry_valid;
	int          mismatches;
	int          waiting;
	int          results_checked;
	int          rule_hits;

	int          requests_sent = 0;
	logic        steady = 1'b0;

	logic [31:0] pool_src   [POOL_SIZE];
	logic [15:0] pool_port  [POOL_SIZE];
	logic [7:0]  pool_proto [POOL_SIZE];

	tcp_syn_acl_packet_filter_core uut (.*);

	tsf_verdict_checker filter_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back to back, some short pauses, a few long ones; none while steady
	function automatic int idle_cycles();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic randomize_fields();
		frame_length = 16'($urandom);
		ethertype    = 16'($urandom);
		header_words = 4'($urandom);
		ip_protocol  = 8'($urandom);
		src_address  = $urandom;
		dest_port    = 16'($urandom);
		syn_flag     = 1'($urandom);
		ack_flag     = 1'($urandom);
		rule_index   = 4'($urandom);
		rule_enable  = 1'($urandom);
	endtask

	// called at a falling edge with the request fields in place
	task automatic push_request();
		int gap;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		requests_sent++;
		@(negedge clk);
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid = 1'b0;
			randomize_fields();
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic classify_req(input logic [15:0] len, input logic [15:0] etype,
		input logic [3:0] hw, input logic [7:0] proto, input logic [31:0] src,
		input logic [15:0] port, input logic syn, input logic ack);
		randomize_fields();
		cmd          = tsf_pkg::CMD_CLASSIFY;
		frame_length = len;
		ethertype    = etype;
		header_words = hw;
		ip_protocol  = proto;
		src_address  = src;
		dest_port    = port;
		syn_flag     = syn;
		ack_flag     = ack;
		push_request();
	endtask

	task automatic write_rule(input logic [3:0] idx, input logic [31:0] src,
		input logic [15:0] port, input logic [7:0] proto, input logic en);
		randomize_fields();
		cmd         = tsf_pkg::CMD_WRITE;
		rule_index  = idx;
		src_address = src;
		dest_port   = port;
		ip_protocol = proto;
		rule_enable = en;
		push_request();
	endtask

	task automatic read_rule(input logic [3:0] idx);
		randomize_fields();
		cmd        = tsf_pkg::CMD_READ;
		rule_index = idx;
		push_request();
	endtask

	task automatic unused_req();
		randomize_fields();
		cmd = CMD_UNUSED;
		push_request();
	endtask

	initial begin
		int hold;
		hold      = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0)
				hold = idle_cycles();
			out_stall = (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	initial begin
		int          n;
		int          r;
		int          k;
		int          hdr_end;
		logic [31:0] src;
		logic [15:0] port;
		logic [7:0]  proto;
		logic [3:0]  hw;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cmd      = tsf_pkg::CMD_CLASSIFY;
		randomize_fields();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// table setup: duplicate key in slots 0 and 3, disabled rule, all-ones and all-zero address and port
		read_rule(4'd0);
		write_rule(4'd0, SRC_A, PORT_A, PROTO_TCP, 1'b1);
		write_rule(4'd3, SRC_A, PORT_A, PROTO_TCP, 1'b1);
		write_rule(4'd15, 32'hFFFF_FFFF, 16'hFFFF, PROTO_TCP, 1'b1);
		write_rule(4'd5, SRC_B, PORT_B, PROTO_TCP, 1'b0);
		write_rule(4'd7, 32'd0, 16'd0, PROTO_TCP, 1'b1);
		// length and protocol checks in order
		classify_req(16'd0, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b0);
		classify_req(16'd13, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b0);
		classify_req(16'd14, ETHERTYPE_IPV6, 4'd5, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b0);
		classify_req(16'd33, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b0);
		classify_req(16'd34, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, SRC_A, PORT_A, 1'b1, 1'b0);
		// header length below five words is taken as given
		classify_req(16'd34, ETHERTYPE_IPV4, 4'd0, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b0);
		classify_req(16'd93, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b0);
		classify_req(16'd94, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b0);
		// flags other than a bare syn pass without lookup
		classify_req(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b1);
		classify_req(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_A, PORT_A, 1'b0, 1'b0);
		classify_req(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_A, PORT_A, 1'b0, 1'b1);
		// disabled rule, miss, extreme keys
		classify_req(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_B, PORT_B, 1'b1, 1'b0);
		classify_req(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_A, 16'd81, 1'b1, 1'b0);
		classify_req(16'hFFFF, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF,
			1'b1, 1'b0);
		classify_req(16'd54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'd0, 16'd0, 1'b1, 1'b0);
		read_rule(4'd0);
		// disabling slot 0 clears its count and hands the key to slot 3
		write_rule(4'd0, SRC_A, PORT_A, PROTO_TCP, 1'b0);
		classify_req(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, SRC_A, PORT_A, 1'b1, 1'b0);
		read_rule(4'd0);
		read_rule(4'd3);
		unused_req();

		// key pool for the random part; the last entry carries a non-tcp protocol
		for (k = 0; k < POOL_SIZE; k++) begin
			pool_src[k]   = $urandom;
			pool_port[k]  = 16'($urandom);
			pool_proto[k] = (k == POOL_SIZE - 1) ? PROTO_UDP : PROTO_TCP;
			write_rule(4'(8 + k), pool_src[k], pool_port[k], pool_proto[k], 1'b1);
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady = ((n / 100) % 4 == 3);
			r = $urandom_range(0, 99);
			k = $urandom_range(0, POOL_SIZE - 1);
			if ($urandom_range(0, 4) != 0) begin
				src   = pool_src[k];
				port  = pool_port[k];
				proto = pool_proto[k];
			end else begin
				src   = $urandom;
				port  = 16'($urandom);
				proto = PROTO_TCP;
			end
			hw = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4))
				: 4'($urandom_range(5, 15));
			hdr_end = 14 + 4 * hw + 20;
			if (r < 10) begin
				write_rule(4'($urandom), src, port, proto, $urandom_range(0, 6) != 0);
			end else if (r < 18) begin
				read_rule(4'($urandom));
			end else if (r < 20) begin
				unused_req();
			end else if (r < 75) begin
				// well-formed bare syn, now and then just short of the tcp header end
				r = $urandom_range(0, 19);
				if (r == 0)
					classify_req(16'(hdr_end - $urandom_range(1, 4)), ETHERTYPE_IPV4, hw,
						PROTO_TCP, src, port, 1'b1, 1'b0);
				else if (r < 5)
					classify_req(16'($urandom_range(hdr_end, 65535)), ETHERTYPE_IPV4, hw,
						PROTO_TCP, src, port, 1'b1, 1'b0);
				else
					classify_req(16'(hdr_end + $urandom_range(0, 1500)), ETHERTYPE_IPV4, hw,
						PROTO_TCP, src, port, 1'b1, 1'b0);
			end else if (r < 90) begin
				classify_req(16'(hdr_end + $urandom_range(0, 1500)), ETHERTYPE_IPV4, hw,
					PROTO_TCP, src, port, 1'($urandom), 1'($urandom));
			end else begin
				randomize_fields();
				cmd = tsf_pkg::CMD_CLASSIFY;
				if ($urandom_range(0, 1))
					ethertype = ETHERTYPE_IPV4;
				if ($urandom_range(0, 1))
					ip_protocol = PROTO_TCP;
				if ($urandom_range(0, 1))
					frame_length = 16'($urandom_range(0, 120));
				push_request();
			end
		end
		steady   = 1'b0;
		in_valid = 1'b0;

		while (waiting != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d requests driven, %0d results compared, %0d rule table hits",
			requests_sent, results_checked, rule_hits);
		if (mismatches == 0 && waiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
hdl/tsf_pkg.sv
hdl/tsf_frame_check.sv
hdl/tsf_rule_table.sv
hdl/tcp_syn_acl_packet_filter_core.sv
verif/tsf_verdict_checker.sv
verif/tb_tcp_syn_acl_packet_filter_core.sv
